// File: hw/rtl/glrs_pkg.sv
// Shared types, constants and Q8.24 arithmetic helpers for the gated linear recurrence scan.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package glrs_pkg;

    // Fixed-point format and field widths
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 24;
    localparam int LANE_IN_W = 10;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int WIDE_W    = PROD_W - FRAC_BITS + 1;
    localparam int EXT_W     = WIDE_W - DATA_W;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Step direction codes
    localparam logic FUNC_FWD = 1'b0;
    localparam logic FUNC_BWD = 1'b1;

    typedef logic signed [DATA_W-1:0] q_t;

    localparam q_t Q_MAX = q_t'({1'b0, {(DATA_W-1){1'b1}}});
    localparam q_t Q_MIN = q_t'({1'b1, {(DATA_W-1){1'b0}}});

    // Operation carried from the front to the back
    typedef struct packed {
        logic func;
        logic first;
        q_t   gate;
        q_t   addend;
        q_t   aux;
    } op_t;

    // Clamp a wide signed value to the 32-bit range
    function automatic q_t sat_q(input logic signed [WIDE_W-1:0] v);
        q_t r;
        if (v[WIDE_W-1] && !(&v[WIDE_W-2:DATA_W-1])) begin
            r = Q_MIN;
        end else if (!v[WIDE_W-1] && (|v[WIDE_W-2:DATA_W-1])) begin
            r = Q_MAX;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // Drop the fraction bits of a full product (floor), then clamp
    function automatic q_t mul_q(input logic signed [PROD_W-1:0] p);
        logic signed [WIDE_W-1:0] w;
        w = {p[PROD_W-1], p[PROD_W-1:FRAC_BITS]};
        return sat_q(w);
    endfunction

    // Exact sum, then clamp
    function automatic q_t add_q(input q_t a, input q_t b);
        logic signed [WIDE_W-1:0] s;
        s = {{EXT_W{a[DATA_W-1]}}, a} + {{EXT_W{b[DATA_W-1]}}, b};
        return sat_q(s);
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/glrs_front.sv
// Front end: takes input beats, folds the lane number into the table range, packs the operation.
// Depends on glrs_pkg.
`default_nettype none

module glrs_front #(
    parameter int LANES = 1024,
    parameter int IDX_W = 10
) (
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_func,
    input  wire logic [glrs_pkg::LANE_IN_W-1:0]   s_lane,
    input  wire logic                             s_first,
    input  wire logic signed [glrs_pkg::DATA_W-1:0] s_gate,
    input  wire logic signed [glrs_pkg::DATA_W-1:0] s_addend,
    input  wire logic signed [glrs_pkg::DATA_W-1:0] s_aux,
    input  wire logic                             q_full,
    output logic                                  push_valid,
    output logic [IDX_W-1:0]                      push_lane,
    output glrs_pkg::op_t                         push_op
);

    logic [glrs_pkg::LANE_IN_W-1:0] rem;

    // Wrap the lane modulo LANES by restoring reduction on the 10-bit number
    always_comb begin
        rem = s_lane;
        for (int k = glrs_pkg::LANE_IN_W - 1; k >= 0; k--) begin
            if (32'(rem) >= (32'(LANES) << k)) begin
                rem = rem - glrs_pkg::LANE_IN_W'(32'(LANES) << k);
            end
        end
    end

    // Accept while the queue has room
    assign s_ready    = !q_full;
    assign push_valid = s_valid && !q_full;
    assign push_lane  = IDX_W'(rem);

    always_comb begin
        push_op.func   = s_func;
        push_op.first  = s_first;
        push_op.gate   = s_gate;
        push_op.addend = s_addend;
        push_op.aux    = s_aux;
    end

endmodule

`default_nettype wire

// File: hw/rtl/glrs_queue.sv
// Short FIFO of decoded operations between the front end and the execution back end.
// Depends on glrs_pkg.
`default_nettype none

module glrs_queue #(
    parameter int IDX_W = 10
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push_valid,
    input  wire logic [IDX_W-1:0]  push_lane,
    input  wire glrs_pkg::op_t     push_op,
    output logic                   q_full,
    output logic                   q_valid,
    output logic [IDX_W-1:0]       q_lane,
    output glrs_pkg::op_t          q_op,
    input  wire logic              q_pop
);

    glrs_pkg::op_t                ops_reg   [glrs_pkg::QUEUE_DEPTH];
    logic [IDX_W-1:0]             lanes_reg [glrs_pkg::QUEUE_DEPTH];
    logic [glrs_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [glrs_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [glrs_pkg::QCNT_W-1:0]  count_reg, count_next;
    logic                         do_push;
    logic                         do_pop;

    assign q_full  = (count_reg == glrs_pkg::QCNT_W'(glrs_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_lane  = lanes_reg[rd_ptr_reg];
    assign q_op    = ops_reg[rd_ptr_reg];

    assign do_push = push_valid && !q_full;
    assign do_pop  = q_pop && q_valid;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge aclk) begin
        if (do_push) begin
            ops_reg[wr_ptr_reg]   <= push_op;
            lanes_reg[wr_ptr_reg] <= push_lane;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/glrs_back.sv
// Back end: running-value table, read/add/multiply/round pipeline, writeback and output register.
// Depends on glrs_pkg.
`default_nettype none

module glrs_back #(
    parameter int LANES = 1024,
    parameter int IDX_W = 10
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              q_valid,
    input  wire logic [IDX_W-1:0]                  q_lane,
    input  wire glrs_pkg::op_t                     q_op,
    output logic                                   q_pop,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [glrs_pkg::DATA_W-1:0]     m_value,
    output logic signed [glrs_pkg::DATA_W-1:0]     m_grad_gate,
    output logic signed [glrs_pkg::DATA_W-1:0]     m_grad_prev
);

    // Running-value table
    logic [glrs_pkg::DATA_W-1:0] mem [LANES];
    glrs_pkg::q_t                rd_data_reg;

    // Stage 1: table data arrives
    logic                  v1_reg;
    glrs_pkg::op_t         op1_reg;
    logic [IDX_W-1:0]      lane1_reg;
    glrs_pkg::q_t          a1;

    // Stage 2: multiply
    logic                  v2_reg;
    glrs_pkg::op_t         op2_reg;
    logic [IDX_W-1:0]      lane2_reg;
    glrs_pkg::q_t          a2_reg;
    logic signed [glrs_pkg::PROD_W-1:0] prod_g;
    logic signed [glrs_pkg::PROD_W-1:0] prod_x;

    // Stage 3: round, add, write back
    logic                  v3_reg;
    logic                  func3_reg;
    logic [IDX_W-1:0]      lane3_reg;
    glrs_pkg::q_t          a3_reg;
    glrs_pkg::q_t          addend3_reg;
    logic signed [glrs_pkg::PROD_W-1:0] pg3_reg;
    logic signed [glrs_pkg::PROD_W-1:0] px3_reg;
    glrs_pkg::q_t          qg3;
    glrs_pkg::q_t          qx3;
    glrs_pkg::q_t          res_value;
    glrs_pkg::q_t          res_gate;
    glrs_pkg::q_t          res_prev;
    glrs_pkg::q_t          wr_data;

    // Output register
    logic                  out_valid_reg;
    glrs_pkg::q_t          out_value_reg;
    glrs_pkg::q_t          out_gate_reg;
    glrs_pkg::q_t          out_prev_reg;

    logic                  en;
    logic                  hazard;
    logic                  issue;
    logic                  wr_en;

    // Advance the whole pipeline whenever the output register can take a beat
    assign en = !out_valid_reg || m_ready;

    // Hold a step that reads the table while an older step on its lane has not written back
    assign hazard = !q_op.first &&
                    ((v1_reg && (lane1_reg == q_lane)) ||
                     (v2_reg && (lane2_reg == q_lane)) ||
                     (v3_reg && (lane3_reg == q_lane)));

    assign issue = en && q_valid && !hazard;
    assign q_pop = issue;
    assign wr_en = en && v3_reg;

    // Table read on issue, write from the last stage
    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_data_reg <= mem[q_lane];
        end
        if (wr_en) begin
            mem[lane3_reg] <= wr_data;
        end
    end

    // Stage 1: pick the previous cell, or form the accumulated gradient
    always_comb begin
        if (op1_reg.func == glrs_pkg::FUNC_FWD) begin
            a1 = op1_reg.first ? op1_reg.aux : rd_data_reg;
        end else begin
            a1 = glrs_pkg::add_q(op1_reg.addend, op1_reg.first ? '0 : rd_data_reg);
        end
    end

    // Stage 2: full products against gate and aux
    assign prod_g = $signed(a2_reg) * $signed(op2_reg.gate);
    assign prod_x = $signed(a2_reg) * $signed(op2_reg.aux);

    // Stage 3: round products, finish forward add, choose write value
    always_comb begin
        qg3 = glrs_pkg::mul_q(pg3_reg);
        qx3 = glrs_pkg::mul_q(px3_reg);
        if (func3_reg == glrs_pkg::FUNC_FWD) begin
            res_value = glrs_pkg::add_q(qg3, addend3_reg);
            res_gate  = '0;
            res_prev  = '0;
            wr_data   = res_value;
        end else begin
            res_value = a3_reg;
            res_gate  = qx3;
            res_prev  = qg3;
            wr_data   = qg3;
        end
    end

    // Stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg        <= issue;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge aclk) begin
        if (en) begin
            op1_reg     <= q_op;
            lane1_reg   <= q_lane;
            op2_reg     <= op1_reg;
            lane2_reg   <= lane1_reg;
            a2_reg      <= a1;
            func3_reg   <= op2_reg.func;
            lane3_reg   <= lane2_reg;
            a3_reg      <= a2_reg;
            addend3_reg <= op2_reg.addend;
            pg3_reg     <= prod_g;
            px3_reg     <= prod_x;
            if (v3_reg) begin
                out_value_reg <= res_value;
                out_gate_reg  <= res_gate;
                out_prev_reg  <= res_prev;
            end
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_value     = out_value_reg;
    assign m_grad_gate = out_gate_reg;
    assign m_grad_prev = out_prev_reg;

endmodule

`default_nettype wire

// File: hw/rtl/gated_linear_recurrence_scan_top.sv
// Top level of the gated linear recurrence scan: front end, operation queue, execution back end.
// Depends on glrs_pkg, glrs_front, glrs_queue and glrs_back.
//
// Usage:
//   Input channel (s_valid/s_ready) carries one step per beat: direction (s_func), lane,
//   first-of-sequence flag, gate, addend and aux in signed Q8.24. The result channel
//   (m_valid/m_ready) returns one beat per step: value, grad_gate, grad_prev.
//   Lanes at or above LANES wrap modulo LANES.
//   From the accepting edge to m_valid when the pipeline is free, a step passes the queue,
//   table read, add, multiply, then round/write back into the output register.
//   Throughput: one step per cycle while the output is not stalled and no step waits on its lane.
//   A step with first clear waits until every older step on the same lane has written
//   the table, so steps on one lane cannot issue back to back; the table's
//   read-after-write loop through the multiplier sets their spacing.
//   Reset empties the queue and pipeline, so s_ready is high when reset is released.
//   The table is not cleared: the first step on each lane must have first set.
//   When m_ready is low with a beat held, the output register keeps it and the pipeline freezes;
//   the 4-entry queue keeps taking input beats until it fills, then s_ready drops.
`default_nettype none

module gated_linear_recurrence_scan_top #(
    parameter int LANES = 1024
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_func,
    input  wire logic [glrs_pkg::LANE_IN_W-1:0]    s_lane,
    input  wire logic                              s_first,
    input  wire logic signed [glrs_pkg::DATA_W-1:0] s_gate,
    input  wire logic signed [glrs_pkg::DATA_W-1:0] s_addend,
    input  wire logic signed [glrs_pkg::DATA_W-1:0] s_aux,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [glrs_pkg::DATA_W-1:0]     m_value,
    output logic signed [glrs_pkg::DATA_W-1:0]     m_grad_gate,
    output logic signed [glrs_pkg::DATA_W-1:0]     m_grad_prev
);

    localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

    logic              push_valid;
    logic [IDX_W-1:0]  push_lane;
    glrs_pkg::op_t     push_op;
    logic              q_full;
    logic              q_valid;
    logic [IDX_W-1:0]  q_lane;
    glrs_pkg::op_t     q_op;
    logic              q_pop;

    glrs_front #(
        .LANES (LANES),
        .IDX_W (IDX_W)
    ) u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_lane     (s_lane),
        .s_first    (s_first),
        .s_gate     (s_gate),
        .s_addend   (s_addend),
        .s_aux      (s_aux),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_lane  (push_lane),
        .push_op    (push_op)
    );

    glrs_queue #(
        .IDX_W (IDX_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_lane  (push_lane),
        .push_op    (push_op),
        .q_full     (q_full),
        .q_valid    (q_valid),
        .q_lane     (q_lane),
        .q_op       (q_op),
        .q_pop      (q_pop)
    );

    glrs_back #(
        .LANES (LANES),
        .IDX_W (IDX_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_lane      (q_lane),
        .q_op        (q_op),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_grad_gate (m_grad_gate),
        .m_grad_prev (m_grad_prev)
    );

endmodule

`default_nettype wire

// File: hw/rtl/glrs_checker.sv
// Port-level checks for the gated linear recurrence scan, bound to the top level.
// Depends on glrs_pkg and gated_linear_recurrence_scan_top.
`default_nettype none

module glrs_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_valid,
    input wire logic                              s_ready,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic signed [glrs_pkg::DATA_W-1:0] m_value,
    input wire logic signed [glrs_pkg::DATA_W-1:0] m_grad_gate,
    input wire logic signed [glrs_pkg::DATA_W-1:0] m_grad_prev
);

    localparam int IN_FLIGHT_MAX = glrs_pkg::QUEUE_DEPTH + 4;

    logic [3:0] pend_reg, pend_next;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = s_valid && s_ready;
    assign out_beat = m_valid && m_ready;

    // Track steps taken but not yet returned
    always_comb begin
        pend_next = pend_reg;
        if (in_beat && !out_beat) begin
            pend_next = pend_reg + 1'b1;
        end else if (out_beat && !in_beat) begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // Reset leaves no result pending and opens the input
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("result valid or input closed after reset");

    // A stalled result beat holds its payload
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_value) && $stable(m_grad_gate) && $stable(m_grad_prev)))
        else $error("result beat changed while stalled");

    // No result without a step taken for it
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (pend_reg != '0))
        else $error("result beat with no pending step");

    // Steps in flight never exceed queue plus pipeline capacity
    a_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg == 4'(IN_FLIGHT_MAX)) |-> !s_ready)
        else $error("input taken beyond block capacity");

endmodule

bind gated_linear_recurrence_scan_top glrs_checker u_glrs_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_value     (m_value),
    .m_grad_gate (m_grad_gate),
    .m_grad_prev (m_grad_prev)
);

`default_nettype wire

// File: tb/sv/tb_gated_linear_recurrence_scan_top.sv
// Self-checking testbench for the gated linear recurrence scan top level.
// Depends on glrs_pkg and gated_linear_recurrence_scan_top; predicts every result beat in-line.

module tb_gated_linear_recurrence_scan_top;

    localparam int            LANES_N  = 1024;
    localparam int            MAX_SEQ  = 12;
    localparam int            MAX_WAYS = 4;
    localparam glrs_pkg::q_t  ONE      = 32'sh0100_0000;

    typedef struct {
        logic                           func;
        logic [glrs_pkg::LANE_IN_W-1:0] lane;
        logic                           first;
        glrs_pkg::q_t                   gate;
        glrs_pkg::q_t                   addend;
        glrs_pkg::q_t                   aux;
    } step_t;

    typedef struct {
        glrs_pkg::q_t value;
        glrs_pkg::q_t grad_gate;
        glrs_pkg::q_t grad_prev;
    } result_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_valid  = 1'b0;
    logic                           s_ready;
    logic                           s_func   = glrs_pkg::FUNC_FWD;
    logic [glrs_pkg::LANE_IN_W-1:0] s_lane   = '0;
    logic                           s_first  = 1'b0;
    glrs_pkg::q_t                   s_gate   = '0;
    glrs_pkg::q_t                   s_addend = '0;
    glrs_pkg::q_t                   s_aux    = '0;
    logic                           m_valid;
    logic                           m_ready  = 1'b0;
    glrs_pkg::q_t                   m_value;
    glrs_pkg::q_t                   m_grad_gate;
    glrs_pkg::q_t                   m_grad_prev;

    // Predicted lane contents: cell after forward steps, carry after backward steps
    glrs_pkg::q_t lane_state[LANES_N];
    bit           lane_touched[LANES_N];
    result_t      pending_results[$];
    result_t      last_result;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;
    int stall_left    = 0;
    int mismatches    = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int n_fwd         = 0;
    int n_bwd         = 0;
    int n_first       = 0;

    gated_linear_recurrence_scan_top #(
        .LANES(LANES_N)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_lane     (s_lane),
        .s_first    (s_first),
        .s_gate     (s_gate),
        .s_addend   (s_addend),
        .s_aux      (s_aux),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_value    (m_value),
        .m_grad_gate(m_grad_gate),
        .m_grad_prev(m_grad_prev)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Bound the run well beyond the slowest legal schedule
    initial begin
        #3_000_000;
        $display("timeout: %0d results still outstanding", pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

    // Q8.24 arithmetic: exact, floor on the dropped fraction, clamp to 32 bits
    function automatic glrs_pkg::q_t clamp_q(input longint v);
        if (v > longint'(glrs_pkg::Q_MAX)) return glrs_pkg::Q_MAX;
        if (v < longint'(glrs_pkg::Q_MIN)) return glrs_pkg::Q_MIN;
        return glrs_pkg::q_t'(v);
    endfunction

    function automatic glrs_pkg::q_t fx_mul(input glrs_pkg::q_t a, input glrs_pkg::q_t b);
        longint prod;
        prod = longint'(a) * longint'(b);
        return clamp_q(prod >>> glrs_pkg::FRAC_BITS);
    endfunction

    function automatic glrs_pkg::q_t fx_add(input glrs_pkg::q_t a, input glrs_pkg::q_t b);
        return clamp_q(longint'(a) + longint'(b));
    endfunction

    // Advance the lane state by one step and return the beat it produces
    function automatic result_t step_predict(input step_t st);
        int           idx;
        glrs_pkg::q_t prev;
        glrs_pkg::q_t acc;
        result_t      r;
        idx = int'(st.lane) % LANES_N;
        if (st.func == glrs_pkg::FUNC_FWD) begin
            prev = st.first ? st.aux : lane_state[idx];
            r.value     = fx_add(fx_mul(prev, st.gate), st.addend);
            r.grad_gate = '0;
            r.grad_prev = '0;
            lane_state[idx] = r.value;
        end else begin
            acc = fx_add(st.addend, st.first ? glrs_pkg::q_t'(0) : lane_state[idx]);
            r.value     = acc;
            r.grad_gate = fx_mul(acc, st.aux);
            r.grad_prev = fx_mul(acc, st.gate);
            lane_state[idx] = r.grad_prev;
        end
        return r;
    endfunction

    function automatic step_t mk_step(input logic func,
                                      input logic [glrs_pkg::LANE_IN_W-1:0] lane,
                                      input logic first, input glrs_pkg::q_t gate,
                                      input glrs_pkg::q_t addend, input glrs_pkg::q_t aux);
        step_t st;
        st.func   = func;
        st.lane   = lane;
        st.first  = first;
        st.gate   = gate;
        st.addend = addend;
        st.aux    = aux;
        return st;
    endfunction

    // Mostly moderate magnitudes, some full-range words, some corner values
    function automatic glrs_pkg::q_t rand_q();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 60) begin
            return glrs_pkg::q_t'(int'($urandom_range(32'h0400_0000)) - 32'sh0200_0000);
        end
        if (sel < 82) return glrs_pkg::q_t'($urandom);
        case ($urandom_range(6))
            0: return glrs_pkg::Q_MAX;
            1: return glrs_pkg::Q_MIN;
            2: return glrs_pkg::q_t'(0);
            3: return glrs_pkg::q_t'(-1);
            4: return glrs_pkg::q_t'(1);
            5: return ONE;
            default: return -ONE;
        endcase
    endfunction

    function automatic glrs_pkg::q_t rand_gate();
        if ($urandom_range(9) < 7) return glrs_pkg::q_t'($urandom_range(ONE));
        return rand_q();
    endfunction

    // Favor a few busy lanes so same-lane hazards are frequent
    function automatic logic [glrs_pkg::LANE_IN_W-1:0] rand_lane();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 5) return glrs_pkg::LANE_IN_W'($urandom_range(7));
        if (sel < 6) return glrs_pkg::LANE_IN_W'(LANES_N - 1 - $urandom_range(3));
        return glrs_pkg::LANE_IN_W'($urandom_range(LANES_N - 1));
    endfunction

    task automatic report_mismatch(input string what, input glrs_pkg::q_t got,
                                   input glrs_pkg::q_t want);
        if (mismatches < 40) begin
            $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
        end
        mismatches++;
    endtask

    // Offer one beat, hold it until accepted, then record its expected result
    task automatic send_step(input step_t st);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_func   <= st.func;
        s_lane   <= st.lane;
        s_first  <= st.first;
        s_gate   <= st.gate;
        s_addend <= st.addend;
        s_aux    <= st.aux;
        lane_touched[int'(st.lane) % LANES_N] = 1'b1;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        last_result = step_predict(st);
        pending_results.push_back(last_result);
        items_sent++;
        if (st.func == glrs_pkg::FUNC_FWD) n_fwd++;
        else n_bwd++;
        if (st.first) n_first++;
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Check result beats and drive the receiver's ready
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("beat with nothing pending, value", m_value, '0);
            end else begin
                want = pending_results.pop_front();
                if (m_value !== want.value) report_mismatch("value", m_value, want.value);
                if (m_grad_gate !== want.grad_gate) begin
                    report_mismatch("grad_gate", m_grad_gate, want.grad_gate);
                end
                if (m_grad_prev !== want.grad_prev) begin
                    report_mismatch("grad_prev", m_grad_prev, want.grad_prev);
                end
            end
        end
        if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
        end
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Saturation both ways, floor rounding, aux ignored on later forward steps
    task automatic test_forward_extremes();
        send_step(mk_step(glrs_pkg::FUNC_FWD, 10'd0, 1'b1, 32'sh0080_0000, 32'sh0040_0000,
                          ONE));
        send_step(mk_step(glrs_pkg::FUNC_FWD, 10'd0, 1'b0, glrs_pkg::Q_MAX, glrs_pkg::Q_MAX,
                          glrs_pkg::Q_MIN));
        send_step(mk_step(glrs_pkg::FUNC_FWD, 10'd0, 1'b0, glrs_pkg::Q_MIN, glrs_pkg::q_t'(0),
                          glrs_pkg::q_t'(0)));
        send_step(mk_step(glrs_pkg::FUNC_FWD, 10'd1023, 1'b1, glrs_pkg::q_t'(1),
                          glrs_pkg::q_t'(0), glrs_pkg::q_t'(-1)));
        send_step(mk_step(glrs_pkg::FUNC_FWD, 10'd1023, 1'b0, glrs_pkg::Q_MIN,
                          glrs_pkg::Q_MIN, glrs_pkg::Q_MAX));
        send_step(mk_step(glrs_pkg::FUNC_FWD, 10'd512, 1'b1, glrs_pkg::Q_MIN, glrs_pkg::Q_MIN,
                          glrs_pkg::Q_MIN));
        send_step(mk_step(glrs_pkg::FUNC_FWD, 10'd512, 1'b0, glrs_pkg::q_t'(0),
                          glrs_pkg::Q_MAX, glrs_pkg::q_t'(0)));
    endtask

    // Carry ignored at the last step, carry added and saturated on earlier steps
    task automatic test_backward_extremes();
        send_step(mk_step(glrs_pkg::FUNC_BWD, 10'd0, 1'b1, glrs_pkg::Q_MIN, glrs_pkg::Q_MAX,
                          glrs_pkg::Q_MAX));
        send_step(mk_step(glrs_pkg::FUNC_BWD, 10'd0, 1'b0, ONE, glrs_pkg::Q_MIN,
                          glrs_pkg::q_t'(-1)));
        send_step(mk_step(glrs_pkg::FUNC_BWD, 10'd0, 1'b0, glrs_pkg::Q_MAX, glrs_pkg::Q_MIN,
                          glrs_pkg::Q_MAX));
        send_step(mk_step(glrs_pkg::FUNC_BWD, 10'd1, 1'b1, glrs_pkg::q_t'(-1),
                          glrs_pkg::q_t'(1), glrs_pkg::q_t'(1)));
        send_step(mk_step(glrs_pkg::FUNC_BWD, 10'd1, 1'b0, -ONE, glrs_pkg::q_t'(-1),
                          glrs_pkg::Q_MIN));
    endtask

    // Both directions on one lane, then back-to-back steps on a single lane
    task automatic test_mixed_directions();
        send_step(mk_step(glrs_pkg::FUNC_FWD, 10'd7, 1'b1, 32'sh00C0_0000, 32'sh0019_999A,
                          32'sh0200_0000));
        send_step(mk_step(glrs_pkg::FUNC_BWD, 10'd7, 1'b0, 32'sh0080_0000, 32'sh0080_0000,
                          32'sh0200_0000));
        send_step(mk_step(glrs_pkg::FUNC_FWD, 10'd7, 1'b0, 32'shFF80_0000, glrs_pkg::q_t'(0),
                          glrs_pkg::q_t'(0)));
        send_step(mk_step(glrs_pkg::FUNC_FWD, 10'd9, 1'b1, ONE, ONE, glrs_pkg::q_t'(0)));
        repeat (4) begin
            send_step(mk_step(glrs_pkg::FUNC_FWD, 10'd9, 1'b0, ONE, ONE, glrs_pkg::Q_MIN));
        end
    endtask

    // Forward pass over a few interleaved lanes, then usually the matching backward pass
    task automatic run_recurrence();
        int                             ways;
        int                             len;
        int                             k;
        int                             t;
        int                             j;
        bit                             clash;
        logic [glrs_pkg::LANE_IN_W-1:0] lanes [MAX_WAYS];
        glrs_pkg::q_t                   init_h[MAX_WAYS];
        glrs_pkg::q_t                   gate_h[MAX_WAYS][MAX_SEQ];
        glrs_pkg::q_t                   cell_h[MAX_WAYS][MAX_SEQ];
        ways = $urandom_range(1, MAX_WAYS);
        len  = ($urandom_range(9) == 0) ? $urandom_range(7, MAX_SEQ) : $urandom_range(1, 6);
        for (k = 0; k < ways; k++) begin
            do begin
                lanes[k] = rand_lane();
                clash = 0;
                for (j = 0; j < k; j++) if (lanes[j] == lanes[k]) clash = 1;
            end while (clash);
            init_h[k] = rand_q();
        end
        for (t = 0; t < len; t++) begin
            for (k = 0; k < ways; k++) begin
                gate_h[k][t] = rand_gate();
                send_step(mk_step(glrs_pkg::FUNC_FWD, lanes[k], t == 0, gate_h[k][t],
                                  rand_q(), (t == 0) ? init_h[k] : rand_q()));
                cell_h[k][t] = last_result.value;
            end
        end
        if ($urandom_range(4) != 0) begin
            for (t = len - 1; t >= 0; t--) begin
                for (k = 0; k < ways; k++) begin
                    send_step(mk_step(glrs_pkg::FUNC_BWD, lanes[k], t == len - 1,
                                      gate_h[k][t], rand_q(),
                                      (t == 0) ? init_h[k] : cell_h[k][t - 1]));
                end
            end
        end
    endtask

    // Loose steps with full-range fields; first forced on lanes never written
    task automatic noise_burst();
        logic [glrs_pkg::LANE_IN_W-1:0] ln;
        logic                           fst;
        repeat ($urandom_range(1, 8)) begin
            ln  = rand_lane();
            fst = lane_touched[ln] ? ($urandom_range(3) == 0) : 1'b1;
            send_step(mk_step(1'($urandom_range(1)), ln, fst, glrs_pkg::q_t'($urandom),
                              glrs_pkg::q_t'($urandom), glrs_pkg::q_t'($urandom)));
        end
    endtask

    task automatic test_random_sequences(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 78) run_recurrence();
            else noise_burst();
        end
    endtask

    // Stall the output for a long stretch while input keeps coming, so s_ready drops
    task automatic test_output_backpressure();
        int stop_at;
        int saved_send;
        int saved_recv;
        saved_send    = send_idle_pct;
        saved_recv    = recv_idle_pct;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 300;
        stop_at = items_sent + 40;
        while (items_sent < stop_at) noise_burst();
        drain_results();
        send_idle_pct = saved_send;
        recv_idle_pct = saved_recv;
    endtask

    initial begin
        send_idle_pct = 13;
        recv_idle_pct = 51;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_forward_extremes();
        test_backward_extremes();
        test_mixed_directions();
        test_random_sequences(340);

        send_idle_pct = 51;
        recv_idle_pct = 13;
        test_random_sequences(340);
        test_output_backpressure();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_sequences(360);

        drain_results();
        repeat (20) @(posedge aclk);

        $display("covered %0d steps: %0d forward, %0d backward, %0d sequence boundaries",
                 items_sent, n_fwd, n_bwd, n_first);
        $display("checked %0d result beats under three idle mixes and one long output stall",
                 results_seen);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/glrs_pkg.sv
hw/rtl/glrs_front.sv
hw/rtl/glrs_queue.sv
hw/rtl/glrs_back.sv
hw/rtl/gated_linear_recurrence_scan_top.sv
hw/rtl/glrs_checker.sv
tb/sv/tb_gated_linear_recurrence_scan_top.sv
